>>> src/ght_pkg.sv
// shared types and codes for the generational handle table
package ght_pkg;

	typedef enum logic [1:0] {
		OP_FIND_OR_CREATE = 2'd0,
		OP_FIND           = 2'd1,
		OP_CHECK          = 2'd2,
		OP_EVICT          = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_MISS    = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_NOT_OCC = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MISS,
		S_POP,
		S_GEN_RD,
		S_GEN_WAIT,
		S_OUT
	} state_t;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 32;

endpackage

>>> src/generational_handle_table_core.sv
// generational handle table: slot map with key scan, generations and a lifo free stack
//
// channel  | direction | tdata (low bit up)                               | tuser
// s_axis   | in        | asset_key 64, slot_number 8, handle_generation 16 | opcode 2
// m_axis   | out       | status 2, created 1, result_slot 8, result_gen 16 | none
//
// one item at a time; find and find_or_create scan the key memory one entry per cycle
// check and evict do a generation read, then the update
// a new item is taken while the previous result still waits in the output register
// reset clears only the control registers; occupied bits sit in the memories and are valid below
// the used count, so no clearing pass is needed
module generational_handle_table_core #(
	parameter int SLOTS    = 256,
	parameter int GEN_BITS = 16,
	parameter int KEY_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// asset_key [63:0], slot_number [71:64], handle_generation [87:72]
	input  logic [ght_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// opcode [1:0]
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status [1:0], created [2], result_slot [10:3], result_generation [26:11], zeros above
	output logic [ght_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	ght_pkg::state_t  state_q, state_d;
	ght_pkg::opcode_t op_q;

	logic [KEY_BITS-1:0] key_q;
	logic [7:0]          sn_q;
	logic [GEN_BITS-1:0] hg_q;
	logic [IW-1:0]       idx_q;
	logic                alloc_q;
	logic [CNT_W-1:0]    used_q, depth_q, scan_q;

	logic                cmp_vld_s1;
	logic [IW-1:0]       cmp_idx_s1;

	logic [1:0]          res_status_q;
	logic                res_created_q;
	logic [7:0]          res_slot_q;
	logic [15:0]         res_gen_q;
	logic                out_vld_q;
	logic [ght_pkg::OUT_DATA_W-1:0] out_data_q;

	// memories, occupied bit on top of each key and generation entry
	logic [KEY_BITS:0]   key_mem [SLOTS];
	logic [GEN_BITS:0]   gen_mem [SLOTS];
	logic [IW-1:0]       stack_mem [SLOTS];
	logic [KEY_BITS:0]   key_word_q;
	logic [GEN_BITS:0]   gen_word_q;
	logic [KEY_BITS-1:0] key_rd;
	logic                key_occ;
	logic [GEN_BITS-1:0] gen_rd;
	logic                gen_occ;
	logic [IW-1:0]       stack_rd;
	assign key_rd  = key_word_q[KEY_BITS-1:0];
	assign key_occ = key_word_q[KEY_BITS];
	assign gen_rd  = gen_word_q[GEN_BITS-1:0];
	assign gen_occ = gen_word_q[GEN_BITS];

	// input unpacking
	logic [63:0]         in_key;
	logic [15:0]         in_sn_ext;
	logic [31:0]         in_hg_ext;
	assign in_key    = s_axis_tdata[63:0];
	assign in_sn_ext = {8'b0, s_axis_tdata[71:64]};
	assign in_hg_ext = {16'b0, s_axis_tdata[87:72]};

	logic [15:0]         sn_ext;
	logic                sn_live;
	assign sn_ext  = {8'b0, sn_q};
	// valid while the generation word of the slot is in gen_word_q
	assign sn_live = (sn_ext < 16'(used_q)) && gen_occ;

	logic [CNT_W-1:0]    depth_m1;
	logic                used_full;
	assign depth_m1  = depth_q - CNT_W'(1);
	assign used_full = (used_q == CNT_W'(SLOTS));

	logic                cmp_hit, cmp_last;
	assign cmp_hit  = cmp_vld_s1 && key_occ && (key_rd == key_q);
	assign cmp_last = cmp_vld_s1 && (CNT_W'(cmp_idx_s1) == used_q - CNT_W'(1));

	logic [GEN_BITS-1:0] gen_inc;
	assign gen_inc = gen_rd + GEN_BITS'(1);

	logic [15:0]         idx_ext;
	assign idx_ext = 16'(idx_q);

	// control strobes
	logic accept, new_alloc, reuse_commit, evict_commit, pop_start, scan_issue, out_load;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ght_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser == ght_pkg::OP_FIND_OR_CREATE ||
					    s_axis_tuser == ght_pkg::OP_FIND) begin
						state_d = (used_q == '0) ? ght_pkg::S_MISS : ght_pkg::S_SCAN;
					end else begin
						state_d = ght_pkg::S_GEN_RD;
					end
				end
			end
			ght_pkg::S_SCAN: begin
				if (cmp_hit) begin
					state_d = ght_pkg::S_GEN_RD;
				end else if (cmp_last) begin
					state_d = ght_pkg::S_MISS;
				end
			end
			ght_pkg::S_MISS: begin
				if (op_q == ght_pkg::OP_FIND_OR_CREATE && depth_q != '0) begin
					state_d = ght_pkg::S_POP;
				end else begin
					state_d = ght_pkg::S_OUT;
				end
			end
			ght_pkg::S_POP:      state_d = ght_pkg::S_GEN_RD;
			ght_pkg::S_GEN_RD:   state_d = ght_pkg::S_GEN_WAIT;
			ght_pkg::S_GEN_WAIT: state_d = ght_pkg::S_OUT;
			ght_pkg::S_OUT: begin
				if (!out_vld_q || m_axis_tready) begin
					state_d = ght_pkg::S_IDLE;
				end
			end
			default: state_d = ght_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ght_pkg::S_IDLE);
		accept        = s_axis_tready && s_axis_tvalid;
		scan_issue    = (state_q == ght_pkg::S_SCAN) && (scan_q < used_q);
		new_alloc     = (state_q == ght_pkg::S_MISS) && (op_q == ght_pkg::OP_FIND_OR_CREATE) &&
		                (depth_q == '0) && !used_full;
		pop_start     = (state_q == ght_pkg::S_MISS) && (op_q == ght_pkg::OP_FIND_OR_CREATE) &&
		                (depth_q != '0);
		reuse_commit  = (state_q == ght_pkg::S_GEN_WAIT) && alloc_q;
		evict_commit  = (state_q == ght_pkg::S_GEN_WAIT) && (op_q == ght_pkg::OP_EVICT) && sn_live;
		out_load      = (state_q == ght_pkg::S_OUT) && (!out_vld_q || m_axis_tready);
	end

	// key memory: scan reads, allocation and eviction write
	always_ff @(posedge clk) begin
		key_word_q <= key_mem[scan_q[IW-1:0]];
		if (new_alloc) begin
			key_mem[used_q[IW-1:0]] <= {1'b1, key_q};
		end else if (reuse_commit) begin
			key_mem[idx_q] <= {1'b1, key_q};
		end else if (evict_commit) begin
			key_mem[idx_q] <= {1'b0, key_q};
		end
	end

	// generation memory: entries below slots_used are always written
	always_ff @(posedge clk) begin
		gen_word_q <= gen_mem[idx_q];
		if (new_alloc) begin
			gen_mem[used_q[IW-1:0]] <= {1'b1, {GEN_BITS{1'b0}}};
		end else if (reuse_commit) begin
			gen_mem[idx_q] <= {1'b1, gen_rd};
		end else if (evict_commit) begin
			gen_mem[idx_q] <= {1'b0, gen_inc};
		end
	end

	// free stack memory
	always_ff @(posedge clk) begin
		stack_rd <= stack_mem[depth_m1[IW-1:0]];
		if (evict_commit && depth_q != CNT_W'(SLOTS)) begin
			stack_mem[depth_q[IW-1:0]] <= idx_q;
		end
	end

	function automatic logic [1:0] STAT_OK_OR(input logic alloc, input logic is_find);
		logic [1:0] s;
		if (alloc) begin
			s = ght_pkg::STAT_OK;
		end else if (is_find) begin
			s = ght_pkg::STAT_MISS;
		end else begin
			s = ght_pkg::STAT_FULL;
		end
		return s;
	endfunction

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= ght_pkg::opcode_t'(s_axis_tuser);
			key_q <= in_key[KEY_BITS-1:0];
			sn_q  <= in_sn_ext[7:0];
			hg_q  <= in_hg_ext[GEN_BITS-1:0];
			idx_q <= in_sn_ext[IW-1:0];
		end else if (state_q == ght_pkg::S_SCAN && cmp_hit) begin
			idx_q <= cmp_idx_s1;
		end else if (state_q == ght_pkg::S_POP) begin
			idx_q <= stack_rd;
		end
		cmp_idx_s1 <= scan_q[IW-1:0];

		unique case (state_q)
			ght_pkg::S_MISS: begin
				res_status_q  <= STAT_OK_OR(new_alloc, op_q == ght_pkg::OP_FIND);
				res_created_q <= new_alloc;
				res_slot_q    <= new_alloc ? 8'(16'(used_q[IW-1:0])) : 8'b0;
				res_gen_q     <= '0;
			end
			ght_pkg::S_GEN_WAIT: begin
				if (op_q == ght_pkg::OP_CHECK) begin
					res_status_q <= (sn_live && gen_rd == hg_q) ? ght_pkg::STAT_OK
					                                            : ght_pkg::STAT_MISS;
					res_slot_q   <= sn_q;
					res_gen_q    <= 16'(32'(hg_q));
				end else if (op_q == ght_pkg::OP_EVICT) begin
					res_status_q <= sn_live ? ght_pkg::STAT_OK : ght_pkg::STAT_NOT_OCC;
					res_slot_q   <= sn_q;
					res_gen_q    <= sn_live ? 16'(32'(gen_inc)) : 16'b0;
				end else begin
					res_status_q <= ght_pkg::STAT_OK;
					res_slot_q   <= idx_ext[7:0];
					res_gen_q    <= 16'(32'(gen_rd));
				end
				res_created_q <= alloc_q;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_data_q <= {5'b0, res_gen_q, res_slot_q, res_created_q, res_status_q};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ght_pkg::S_IDLE;
			used_q     <= '0;
			depth_q    <= '0;
			scan_q     <= '0;
			alloc_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= scan_issue;
			if (accept) begin
				scan_q  <= '0;
				alloc_q <= 1'b0;
			end else if (scan_issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (new_alloc) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (pop_start) begin
				depth_q <= depth_m1;
				alloc_q <= 1'b1;
			end
			if (evict_commit) begin
				if (depth_q != CNT_W'(SLOTS)) begin
					depth_q <= depth_q + CNT_W'(1);
				end
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	// every free slot was taken once
	a_depth_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= used_q)
		else $error("free stack deeper than slots ever used");

	a_used_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> used_q >= $past(used_q))
		else $error("slots_used decreased");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ght_pkg::S_SCAN |-> used_q != '0)
		else $error("key scan over an empty table");

	a_reuse_free: assert property (@(posedge clk) disable iff (!arst_n)
		reuse_commit |-> !gen_occ)
		else $error("slot popped from free stack is occupied");

	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ght_pkg::S_SCAN && cmp_hit) |=> state_q == ght_pkg::S_GEN_RD)
		else $error("key hit did not end the scan");
`endif

endmodule
